[hw/rtl/trs_pkg.sv]
// Shared types, constants and helpers for the thermal ROI statistics block.
// Used by every module under hw/rtl; depends on nothing else.
package trs_pkg;

	localparam int MAX_DIM     = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int DIM_BITS    = $clog2(MAX_DIM);
	localparam int SIZE_BITS   = DIM_BITS + 1;
	localparam int COUNT_BITS  = 2 * DIM_BITS + 1;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int MAG_BITS    = SUM_BITS - 1;
	localparam int REM_BITS    = COUNT_BITS + 1;
	localparam int STEP_BITS   = $clog2(MAG_BITS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = SIZE_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_A_X   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_A_Y   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_B_X   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_B_Y   = 3'd5;

	localparam logic [SIZE_BITS-1:0] RST_FRAME_WIDTH  = SIZE_BITS'(32);
	localparam logic [SIZE_BITS-1:0] RST_FRAME_HEIGHT = SIZE_BITS'(24);

	typedef struct packed {
		logic [SIZE_BITS-1:0] frame_width;
		logic [SIZE_BITS-1:0] frame_height;
		logic [DIM_BITS-1:0]  corner_a_x;
		logic [DIM_BITS-1:0]  corner_a_y;
		logic [DIM_BITS-1:0]  corner_b_x;
		logic [DIM_BITS-1:0]  corner_b_y;
	} cfg_t;

	// Per-frame summary handed from the front to the back end.
	typedef struct packed {
		logic                          stats_valid;
		logic signed [SAMPLE_BITS-1:0] minimum_value;
		logic signed [SAMPLE_BITS-1:0] maximum_value;
		logic signed [SUM_BITS-1:0]    sum;
		logic [COUNT_BITS-1:0]         count;
		logic signed [SAMPLE_BITS-1:0] center_value;
		logic                          center_valid;
		logic [DIM_BITS-1:0]           coldest_x;
		logic [DIM_BITS-1:0]           coldest_y;
		logic [DIM_BITS-1:0]           hottest_x;
		logic [DIM_BITS-1:0]           hottest_y;
	} frame_sum_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_OUTPUT
	} back_state_t;

	// Zero reads as one, anything above MAX_DIM as MAX_DIM.
	function automatic logic [SIZE_BITS-1:0] clamp_dim(input logic [SIZE_BITS-1:0] v);
		logic [SIZE_BITS-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_BITS'(1);
		end else if (v > SIZE_BITS'(MAX_DIM)) begin
			r = SIZE_BITS'(MAX_DIM);
		end
		return r;
	endfunction

endpackage

[hw/rtl/thermal_roi_statistics_top.sv]
// Top level of the thermal ROI statistics block: configuration registers,
// front end, summary queue and divider back end. Uses trs_pkg and trs_*.
//
// Usage:
//   Pixels arrive on in_valid/in_ready (temperature, sample_valid) in
//   detector raster order. One result transaction leaves on
//   out_valid/out_ready after the last pixel of each frame.
//   Registers are written through cfg_write/cfg_index/cfg_data while idle.
// Throughput: the front end takes one pixel per cycle; in_ready drops only
//   when the two-entry summary queue is full.
// Result: the back end forms the average with a one-bit-per-cycle restoring
//   divider after taking a summary from the queue, and skips the divider when
//   the region holds no valid sample.
// Reset: arst_n clears counters, statistics, queue pointers and the back-end
//   state, and sets the frame to 32 x 24 with both corners at the origin.
// Stall: a result waits in the back end until taken; meanwhile up to two
//   further frame summaries queue up before pixel input is held off.
module thermal_roi_statistics_top (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_write,
	input  logic [trs_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
	input  logic [trs_pkg::CFG_DATA_BITS-1:0]           cfg_data,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0]      temperature,
	input  logic                                        sample_valid,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic                                        stats_valid,
	output logic signed [trs_pkg::SAMPLE_BITS-1:0]      minimum_value,
	output logic signed [trs_pkg::SAMPLE_BITS-1:0]      maximum_value,
	output logic signed [trs_pkg::SAMPLE_BITS-1:0]      average_value,
	output logic signed [trs_pkg::SAMPLE_BITS-1:0]      center_value,
	output logic                                        center_valid,
	output logic [trs_pkg::DIM_BITS-1:0]                coldest_x,
	output logic [trs_pkg::DIM_BITS-1:0]                coldest_y,
	output logic [trs_pkg::DIM_BITS-1:0]                hottest_x,
	output logic [trs_pkg::DIM_BITS-1:0]                hottest_y,
	output logic [trs_pkg::COUNT_BITS-1:0]              valid_count
);

	trs_pkg::cfg_t       cfg_q;
	trs_pkg::frame_sum_t push_data, pop_data, result;
	logic                push, pop, q_full, q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= trs_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height <= trs_pkg::RST_FRAME_HEIGHT;
			cfg_q.corner_a_x   <= '0;
			cfg_q.corner_a_y   <= '0;
			cfg_q.corner_b_x   <= '0;
			cfg_q.corner_b_y   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				trs_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				trs_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				trs_pkg::REG_CORNER_A_X:   cfg_q.corner_a_x <= cfg_data[trs_pkg::DIM_BITS-1:0];
				trs_pkg::REG_CORNER_A_Y:   cfg_q.corner_a_y <= cfg_data[trs_pkg::DIM_BITS-1:0];
				trs_pkg::REG_CORNER_B_X:   cfg_q.corner_b_x <= cfg_data[trs_pkg::DIM_BITS-1:0];
				trs_pkg::REG_CORNER_B_Y:   cfg_q.corner_b_y <= cfg_data[trs_pkg::DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	trs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.temperature  (temperature),
		.sample_valid (sample_valid),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	trs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	trs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.average   (average_value)
	);

	assign stats_valid   = result.stats_valid;
	assign minimum_value = result.minimum_value;
	assign maximum_value = result.maximum_value;
	assign center_value  = result.center_value;
	assign center_valid  = result.center_valid;
	assign coldest_x     = result.coldest_x;
	assign coldest_y     = result.coldest_y;
	assign hottest_x     = result.hottest_x;
	assign hottest_y     = result.hottest_y;
	assign valid_count   = result.count;

endmodule

[hw/rtl/trs_front.sv]
// Pixel front end: raster counters, region test and running statistics.
// Pushes one frame_sum_t per frame into the queue. Depends on trs_pkg.
module trs_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  trs_pkg::cfg_t                          cfg,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0] temperature,
	input  logic                                   sample_valid,
	input  logic                                   q_full,
	output logic                                   push,
	output trs_pkg::frame_sum_t                    push_data
);

	logic [trs_pkg::DIM_BITS-1:0]           col_q, row_q;
	logic signed [trs_pkg::SUM_BITS-1:0]    sum_q, sum_n;
	logic [trs_pkg::COUNT_BITS-1:0]         cnt_q, cnt_n;
	logic signed [trs_pkg::SAMPLE_BITS-1:0] min_q, min_n, max_q, max_n;
	logic [trs_pkg::DIM_BITS-1:0]           cold_x_q, cold_y_q, hot_x_q, hot_y_q;
	logic [trs_pkg::DIM_BITS-1:0]           cold_x_n, cold_y_n, hot_x_n, hot_y_n;
	logic signed [trs_pkg::SAMPLE_BITS-1:0] cen_val_q, cen_val_n;
	logic                                   cen_seen_q, cen_seen_n;

	logic [trs_pkg::SIZE_BITS-1:0] w, h, py_full, span, cx, cy;
	logic [trs_pkg::SIZE_BITS-1:0] hm1, wm1;
	logic [trs_pkg::DIM_BITS-1:0]  left, right, top, bottom, right0, bottom0, px, py;
	logic                          region_ok, in_roi, hit, last_col, last_frame, accept;
	logic signed [trs_pkg::SUM_BITS-1:0] t_ext;
	trs_pkg::frame_sum_t           rec;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last_frame;
	assign push_data = rec;

	always_comb begin
		w   = trs_pkg::clamp_dim(cfg.frame_width);
		h   = trs_pkg::clamp_dim(cfg.frame_height);
		hm1 = h - trs_pkg::SIZE_BITS'(1);
		wm1 = w - trs_pkg::SIZE_BITS'(1);

		// Normalize the corners, then clip to the rotated image.
		left    = (cfg.corner_a_x < cfg.corner_b_x) ? cfg.corner_a_x : cfg.corner_b_x;
		right0  = (cfg.corner_a_x < cfg.corner_b_x) ? cfg.corner_b_x : cfg.corner_a_x;
		top     = (cfg.corner_a_y < cfg.corner_b_y) ? cfg.corner_a_y : cfg.corner_b_y;
		bottom0 = (cfg.corner_a_y < cfg.corner_b_y) ? cfg.corner_b_y : cfg.corner_a_y;
		right   = (trs_pkg::SIZE_BITS'(right0) > hm1) ? hm1[trs_pkg::DIM_BITS-1:0] : right0;
		bottom  = (trs_pkg::SIZE_BITS'(bottom0) > wm1) ? wm1[trs_pkg::DIM_BITS-1:0] : bottom0;
		region_ok = (left <= right) && (top <= bottom);

		px      = row_q;
		py_full = wm1 - trs_pkg::SIZE_BITS'(col_q);
		py      = py_full[trs_pkg::DIM_BITS-1:0];
		in_roi  = region_ok
			&& (trs_pkg::SIZE_BITS'(col_q) < w)
			&& (trs_pkg::SIZE_BITS'(row_q) < h)
			&& (px >= left) && (px <= right) && (py >= top) && (py <= bottom);
		hit = in_roi && sample_valid;

		span = trs_pkg::SIZE_BITS'(right) - trs_pkg::SIZE_BITS'(left) + trs_pkg::SIZE_BITS'(1);
		cx   = trs_pkg::SIZE_BITS'(left) + (span >> 1);
		span = trs_pkg::SIZE_BITS'(bottom) - trs_pkg::SIZE_BITS'(top) + trs_pkg::SIZE_BITS'(1);
		cy   = trs_pkg::SIZE_BITS'(top) + (span >> 1);

		last_col   = (trs_pkg::SIZE_BITS'(col_q) + trs_pkg::SIZE_BITS'(1)) >= w;
		last_frame = last_col && ((trs_pkg::SIZE_BITS'(row_q) + trs_pkg::SIZE_BITS'(1)) >= h);

		t_ext = {{(trs_pkg::SUM_BITS - trs_pkg::SAMPLE_BITS){temperature[trs_pkg::SAMPLE_BITS-1]}},
			temperature};

		sum_n    = sum_q;
		cnt_n    = cnt_q;
		min_n    = min_q;
		max_n    = max_q;
		cold_x_n = cold_x_q;
		cold_y_n = cold_y_q;
		hot_x_n  = hot_x_q;
		hot_y_n  = hot_y_q;
		if (hit) begin
			sum_n = sum_q + t_ext;
			cnt_n = cnt_q + trs_pkg::COUNT_BITS'(1);
			if (cnt_q == '0) begin
				min_n    = temperature;
				max_n    = temperature;
				cold_x_n = px;
				cold_y_n = py;
				hot_x_n  = px;
				hot_y_n  = py;
			end else begin
				// Equal values move the position only if earlier in image raster order.
				if ((temperature < min_q) || ((temperature == min_q)
					&& ((py < cold_y_q) || ((py == cold_y_q) && (px < cold_x_q))))) begin
					min_n    = temperature;
					cold_x_n = px;
					cold_y_n = py;
				end
				if ((temperature > max_q) || ((temperature == max_q)
					&& ((py < hot_y_q) || ((py == hot_y_q) && (px < hot_x_q))))) begin
					max_n   = temperature;
					hot_x_n = px;
					hot_y_n = py;
				end
			end
		end

		cen_val_n  = cen_val_q;
		cen_seen_n = cen_seen_q;
		if (in_roi && (trs_pkg::SIZE_BITS'(px) == cx) && (trs_pkg::SIZE_BITS'(py) == cy)) begin
			cen_seen_n = sample_valid;
			cen_val_n  = sample_valid ? temperature : '0;
		end

		rec = '0;
		if (region_ok && (cnt_n != '0)) begin
			rec.stats_valid   = 1'b1;
			rec.minimum_value = min_n;
			rec.maximum_value = max_n;
			rec.sum           = sum_n;
			rec.count         = cnt_n;
			rec.center_value  = cen_seen_n ? cen_val_n : '0;
			rec.center_valid  = cen_seen_n;
			rec.coldest_x     = cold_x_n;
			rec.coldest_y     = cold_y_n;
			rec.hottest_x     = hot_x_n;
			rec.hottest_y     = hot_y_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			min_q      <= '0;
			max_q      <= '0;
			cold_x_q   <= '0;
			cold_y_q   <= '0;
			hot_x_q    <= '0;
			hot_y_q    <= '0;
			cen_val_q  <= '0;
			cen_seen_q <= 1'b0;
		end else if (accept) begin
			if (last_frame) begin
				// Frame summary leaves through push_data; start over.
				col_q      <= '0;
				row_q      <= '0;
				sum_q      <= '0;
				cnt_q      <= '0;
				min_q      <= '0;
				max_q      <= '0;
				cold_x_q   <= '0;
				cold_y_q   <= '0;
				hot_x_q    <= '0;
				hot_y_q    <= '0;
				cen_val_q  <= '0;
				cen_seen_q <= 1'b0;
			end else begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + trs_pkg::DIM_BITS'(1);
				end else begin
					col_q <= col_q + trs_pkg::DIM_BITS'(1);
				end
				sum_q      <= sum_n;
				cnt_q      <= cnt_n;
				min_q      <= min_n;
				max_q      <= max_n;
				cold_x_q   <= cold_x_n;
				cold_y_q   <= cold_y_n;
				hot_x_q    <= hot_x_n;
				hot_y_q    <= hot_y_n;
				cen_val_q  <= cen_val_n;
				cen_seen_q <= cen_seen_n;
			end
		end
	end

endmodule

[hw/rtl/trs_queue.sv]
// Short FIFO of frame summaries between front and back end.
// Depends on trs_pkg for the entry type and depth.
module trs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  trs_pkg::frame_sum_t push_data,
	output logic                full,
	input  logic                pop,
	output trs_pkg::frame_sum_t pop_data,
	output logic                not_empty
);

	trs_pkg::frame_sum_t              entry_q [trs_pkg::QUEUE_DEPTH];
	logic [trs_pkg::QPTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
	logic [trs_pkg::QPTR_BITS:0]      count_q;

	assign full      = (count_q == (trs_pkg::QPTR_BITS + 1)'(trs_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == trs_pkg::QPTR_BITS'(trs_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + trs_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == trs_pkg::QPTR_BITS'(trs_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + trs_pkg::QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (trs_pkg::QPTR_BITS + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (trs_pkg::QPTR_BITS + 1)'(1);
			end
		end
	end

endmodule

[hw/rtl/trs_back.sv]
// Back end: takes a frame summary, forms the average with a one bit per
// cycle restoring divider and holds the result until it is taken. Uses trs_pkg.
module trs_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  trs_pkg::frame_sum_t                    q_data,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output trs_pkg::frame_sum_t                    result,
	output logic signed [trs_pkg::SAMPLE_BITS-1:0] average
);

	trs_pkg::back_state_t                state_q, state_n;
	trs_pkg::frame_sum_t                 rec_q;
	logic [trs_pkg::MAG_BITS-1:0]        quo_q;
	logic [trs_pkg::COUNT_BITS-1:0]      rem_q, rem_n;
	logic [trs_pkg::STEP_BITS-1:0]       step_q;
	logic                                neg_q;
	logic [trs_pkg::REM_BITS-1:0]        rem_sh, rem_diff;
	logic                                fits;
	logic signed [trs_pkg::SUM_BITS-1:0] abs_sum;
	logic                                last_step;

	always_comb begin
		abs_sum  = q_data.sum[trs_pkg::SUM_BITS-1] ? -q_data.sum : q_data.sum;
		rem_sh   = {rem_q, quo_q[trs_pkg::MAG_BITS-1]};
		rem_diff = rem_sh - trs_pkg::REM_BITS'(rec_q.count);
		fits     = rem_sh >= trs_pkg::REM_BITS'(rec_q.count);
		rem_n    = fits ? rem_diff[trs_pkg::COUNT_BITS-1:0] : rem_sh[trs_pkg::COUNT_BITS-1:0];
		last_step = (step_q == trs_pkg::STEP_BITS'(trs_pkg::MAG_BITS - 1));
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			trs_pkg::ST_IDLE: begin
				if (q_valid) begin
					// Empty statistics skip the divider; the quotient loads as zero.
					state_n = q_data.stats_valid ? trs_pkg::ST_DIVIDE : trs_pkg::ST_OUTPUT;
				end
			end
			trs_pkg::ST_DIVIDE: begin
				if (last_step) begin
					state_n = trs_pkg::ST_OUTPUT;
				end
			end
			trs_pkg::ST_OUTPUT: begin
				if (out_ready) begin
					state_n = trs_pkg::ST_IDLE;
				end
			end
			default: state_n = trs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == trs_pkg::ST_IDLE) && q_valid;
		out_valid = (state_q == trs_pkg::ST_OUTPUT);
		result    = rec_q;
		average   = neg_q ? -quo_q[trs_pkg::SAMPLE_BITS-1:0] : quo_q[trs_pkg::SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trs_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q  <= q_data;
			neg_q  <= q_data.sum[trs_pkg::SUM_BITS-1];
			quo_q  <= abs_sum[trs_pkg::MAG_BITS-1:0];
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == trs_pkg::ST_DIVIDE) begin
			// Shift the dividend through, one quotient bit per cycle.
			rem_q  <= rem_n;
			quo_q  <= {quo_q[trs_pkg::MAG_BITS-2:0], fits};
			step_q <= step_q + trs_pkg::STEP_BITS'(1);
		end
	end

endmodule

[test/roi_stats_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for thermal_roi_statistics_top: follows register writes and pixel
// transactions, predicts each frame result and compares it field by field.
// Depends on trs_pkg for widths, register indexes and reset values.
module roi_stats_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [trs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [trs_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0] temperature,
	input  logic                                   sample_valid,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic                                   stats_valid,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0] minimum_value,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0] maximum_value,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0] average_value,
	input  logic signed [trs_pkg::SAMPLE_BITS-1:0] center_value,
	input  logic                                   center_valid,
	input  logic [trs_pkg::DIM_BITS-1:0]           coldest_x,
	input  logic [trs_pkg::DIM_BITS-1:0]           coldest_y,
	input  logic [trs_pkg::DIM_BITS-1:0]           hottest_x,
	input  logic [trs_pkg::DIM_BITS-1:0]           hottest_y,
	input  logic [trs_pkg::COUNT_BITS-1:0]         valid_count,
	output int                                     fail_count,
	output int                                     pending_results,
	output int                                     frames_checked,
	output int                                     frames_with_stats
);
	import trs_pkg::*;

	typedef struct packed {
		logic                   stats_valid;
		logic [SAMPLE_BITS-1:0] minimum_value;
		logic [SAMPLE_BITS-1:0] maximum_value;
		logic [SAMPLE_BITS-1:0] average_value;
		logic [SAMPLE_BITS-1:0] center_value;
		logic                   center_valid;
		logic [DIM_BITS-1:0]    coldest_x;
		logic [DIM_BITS-1:0]    coldest_y;
		logic [DIM_BITS-1:0]    hottest_x;
		logic [DIM_BITS-1:0]    hottest_y;
		logic [COUNT_BITS-1:0]  valid_count;
	} roi_result_t;

	roi_result_t frame_results_q[$];

	logic [SIZE_BITS-1:0] reg_width, reg_height;
	logic [DIM_BITS-1:0]  reg_ax, reg_ay, reg_bx, reg_by;

	int                            det_col, det_row;
	longint                        acc_sum;
	int                            acc_count;
	logic signed [SAMPLE_BITS-1:0] acc_min, acc_max;
	int                            cold_px, cold_py, hot_px, hot_py;
	logic signed [SAMPLE_BITS-1:0] mid_temp;
	logic                          mid_valid;

	function automatic int active_dim(logic [SIZE_BITS-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	// Image raster order: smaller y first, then smaller x.
	function automatic bit raster_first(int x, int y, int old_x, int old_y);
		return (y < old_y) || (y == old_y && x < old_x);
	endfunction

	task automatic restart_frame();
		det_col   = 0;
		det_row   = 0;
		acc_sum   = 0;
		acc_count = 0;
		acc_min   = '0;
		acc_max   = '0;
		cold_px   = 0;
		cold_py   = 0;
		hot_px    = 0;
		hot_py    = 0;
		mid_temp  = '0;
		mid_valid = 1'b0;
	endtask

	task automatic accumulate_pixel(logic signed [SAMPLE_BITS-1:0] t, logic ok);
		int          w, h, x_lo, x_hi, y_lo, y_hi, px, py;
		bit          region_ok, in_region;
		roi_result_t r;
		w    = active_dim(reg_width);
		h    = active_dim(reg_height);
		x_lo = (reg_ax < reg_bx) ? reg_ax : reg_bx;
		x_hi = (reg_ax < reg_bx) ? reg_bx : reg_ax;
		y_lo = (reg_ay < reg_by) ? reg_ay : reg_by;
		y_hi = (reg_ay < reg_by) ? reg_by : reg_ay;
		if (x_hi > h - 1) begin
			x_hi = h - 1;
		end
		if (y_hi > w - 1) begin
			y_hi = w - 1;
		end
		region_ok = (x_lo <= x_hi) && (y_lo <= y_hi);
		// Rotate: image x is the detector row, image y counts columns from the right.
		px        = det_row;
		py        = w - 1 - det_col;
		in_region = region_ok && py >= 0 && px < h && px >= x_lo && px <= x_hi &&
			py >= y_lo && py <= y_hi;
		if (in_region && ok) begin
			acc_sum += t;
			if (acc_count == 0) begin
				acc_min = t;
				acc_max = t;
				cold_px = px;
				cold_py = py;
				hot_px  = px;
				hot_py  = py;
			end else begin
				if (t < acc_min || (t == acc_min && raster_first(px, py, cold_px, cold_py))) begin
					acc_min = t;
					cold_px = px;
					cold_py = py;
				end
				if (t > acc_max || (t == acc_max && raster_first(px, py, hot_px, hot_py))) begin
					acc_max = t;
					hot_px  = px;
					hot_py  = py;
				end
			end
			acc_count++;
		end
		// The center pixel is captured even when its sample is not valid.
		if (in_region && px == x_lo + (x_hi - x_lo + 1) / 2 &&
				py == y_lo + (y_hi - y_lo + 1) / 2) begin
			mid_valid = ok;
			mid_temp  = ok ? t : '0;
		end
		if (det_col + 1 < w) begin
			det_col++;
		end else if (det_row + 1 < h) begin
			det_col = 0;
			det_row++;
		end else begin
			r = '0;
			if (region_ok && acc_count > 0) begin
				r.stats_valid   = 1'b1;
				r.minimum_value = acc_min;
				r.maximum_value = acc_max;
				r.average_value = SAMPLE_BITS'(acc_sum / longint'(acc_count));
				r.center_value  = mid_temp;
				r.center_valid  = mid_valid;
				r.coldest_x     = DIM_BITS'(cold_px);
				r.coldest_y     = DIM_BITS'(cold_py);
				r.hottest_x     = DIM_BITS'(hot_px);
				r.hottest_y     = DIM_BITS'(hot_py);
				r.valid_count   = COUNT_BITS'(acc_count);
			end
			frame_results_q.push_back(r);
			restart_frame();
		end
	endtask

	task automatic check_field(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
		end
	endtask

	task automatic check_result();
		roi_result_t want;
		if (frame_results_q.size() == 0) begin
			fail_count++;
			$display("%0t: result transaction with none outstanding, expected none, %s %0d %0d",
				$time, "actual stats_valid and valid_count", stats_valid, valid_count);
		end else begin
			want = frame_results_q.pop_front();
			frames_checked++;
			if (want.stats_valid) begin
				frames_with_stats++;
			end
			check_field("stats_valid", want.stats_valid, stats_valid);
			check_field("minimum_value", $signed(want.minimum_value), minimum_value);
			check_field("maximum_value", $signed(want.maximum_value), maximum_value);
			check_field("average_value", $signed(want.average_value), average_value);
			check_field("center_value", $signed(want.center_value), center_value);
			check_field("center_valid", want.center_valid, center_valid);
			check_field("coldest_x", want.coldest_x, coldest_x);
			check_field("coldest_y", want.coldest_y, coldest_y);
			check_field("hottest_x", want.hottest_x, hottest_x);
			check_field("hottest_y", want.hottest_y, hottest_y);
			check_field("valid_count", want.valid_count, valid_count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_width  = RST_FRAME_WIDTH;
			reg_height = RST_FRAME_HEIGHT;
			reg_ax     = '0;
			reg_ay     = '0;
			reg_bx     = '0;
			reg_by     = '0;
			restart_frame();
			frame_results_q.delete();
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
			end
			if (in_valid && in_ready) begin
				accumulate_pixel(temperature, sample_valid);
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						reg_width = cfg_data;
					end
					REG_FRAME_HEIGHT: begin
						reg_height = cfg_data;
					end
					REG_CORNER_A_X: begin
						reg_ax = cfg_data[DIM_BITS-1:0];
					end
					REG_CORNER_A_Y: begin
						reg_ay = cfg_data[DIM_BITS-1:0];
					end
					REG_CORNER_B_X: begin
						reg_bx = cfg_data[DIM_BITS-1:0];
					end
					REG_CORNER_B_Y: begin
						reg_by = cfg_data[DIM_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			pending_results = frame_results_q.size();
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench top for thermal_roi_statistics_top: writes region settings, streams
// pixel frames with random gaps and throttles results; roi_stats_checker checks.
// Depends on trs_pkg, the block's RTL and test/roi_stats_checker.sv.
module tb;
	import trs_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 48;
	localparam int HOLD_CYCLES  = 300;
	localparam int ITEM_TARGET  = 900;

	typedef enum int {
		TEMP_FULL,
		TEMP_NARROW,
		TEMP_EXTREME,
		TEMP_MODERATE
	} temp_mode_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_write    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	logic signed [SAMPLE_BITS-1:0] temperature = '0;
	logic                      sample_valid = 1'b0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic                      stats_valid;
	logic signed [SAMPLE_BITS-1:0] minimum_value, maximum_value, average_value, center_value;
	logic                      center_valid;
	logic [DIM_BITS-1:0]       coldest_x, coldest_y, hottest_x, hottest_y;
	logic [COUNT_BITS-1:0]     valid_count;

	int fail_count, pending_results, frames_checked, frames_with_stats;
	int pixels_sent   = 0;
	int settings_used = 0;
	int cycle_count   = 0;
	int hold_requests = 0;
	int holds_started = 0;
	int rx_stall      = 0;
	bit tx_quiet      = 1'b0;
	bit rx_quiet      = 1'b0;
	bit rx_took       = 1'b0;

	thermal_roi_statistics_top i_dut (.*);

	roi_stats_checker i_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		rx_took <= out_valid && out_ready;
	end

	// Draw a fresh stall after every result transaction; a hold request wins.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_requests != holds_started) begin
				holds_started++;
				rx_stall = HOLD_CYCLES;
			end else if (rx_took) begin
				rx_stall = rx_quiet ? 0 : $urandom_range(0, 7);
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic int frame_span(int v);
		if (v == 0) begin
			return 1;
		end
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_temp(temp_mode_t mode);
		int v;
		case (mode)
			TEMP_NARROW: begin
				v = int'($urandom_range(0, 6)) - 3;
			end
			TEMP_EXTREME: begin
				if ($urandom_range(0, 1) != 0) begin
					v = 32767 - int'($urandom_range(0, 1));
				end else begin
					v = -32768 + int'($urandom_range(0, 1));
				end
			end
			TEMP_MODERATE: begin
				v = int'($urandom_range(0, 511)) - 256;
			end
			default: begin
				v = int'($urandom_range(0, 65535));
			end
		endcase
		return SAMPLE_BITS'(v);
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(7, 12);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	// Mostly inside or just past the image, now and then anywhere, with bit 10
	// set on some writes since the corner registers keep only ten bits.
	function automatic int pick_corner(int span);
		int v;
		case ($urandom_range(0, 9))
			0: v = 1023;
			1: v = $urandom_range(0, 1023);
			default: v = $urandom_range(0, span);
		endcase
		if ($urandom_range(0, 5) == 0) begin
			v += 1024;
		end
		return v;
	endfunction

	function automatic int pick_valid_pct();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return 50;
			3, 4, 5: return 90;
			default: return 100;
		endcase
	endfunction

	task automatic send_pixel(logic signed [SAMPLE_BITS-1:0] t, logic ok);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		temperature  <= t;
		sample_valid <= ok;
		@(posedge clk);
		while (!(in_valid && in_ready)) @(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(value);
		@(negedge clk);
	endtask

	task automatic apply_setting(int w, int h, int ax, int ay, int bx, int by);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_CORNER_A_X, ax);
		write_reg(REG_CORNER_A_Y, ay);
		write_reg(REG_CORNER_B_X, bx);
		write_reg(REG_CORNER_B_Y, by);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// Stop offering pixels until every frame result is out and the divider is quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_frames(int w, int h, int frames, temp_mode_t mode, int valid_pct);
		int n;
		n = frame_span(w) * frame_span(h) * frames;
		repeat (n) begin
			send_pixel(pick_temp(mode), $urandom_range(1, 100) <= valid_pct);
		end
	endtask

	task automatic run_phase(int w, int h, int ax, int ay, int bx, int by, int frames,
			temp_mode_t mode, int valid_pct);
		drain_results();
		apply_setting(w, h, ax, ay, bx, by);
		send_frames(w, h, frames, mode, valid_pct);
	endtask

	initial begin
		int phase, w, h;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero sizes read as a one-pixel frame: both extremes, then a skipped sample.
		apply_setting(0, 0, 0, 0, 0, 0);
		send_pixel(SAMPLE_BITS'(-32768), 1'b1);
		send_pixel(SAMPLE_BITS'(32767), 1'b1);
		send_pixel(pick_temp(TEMP_FULL), 1'b0);

		// Region entirely beyond the image after clipping.
		run_phase(2, 2, 1023, 1023, 1023, 1023, 1, TEMP_FULL, 100);

		// Corners given swapped, all pixels equal: earliest image position must win.
		drain_results();
		apply_setting(3, 3, 2, 2, 0, 0);
		repeat (9) send_pixel(SAMPLE_BITS'(5), 1'b1);

		// Region is detector row 1: -3 and 2 average to zero, not minus one.
		drain_results();
		apply_setting(2, 3, 1, 0, 1, 1);
		send_pixel(pick_temp(TEMP_FULL), $urandom_range(0, 1));
		send_pixel(pick_temp(TEMP_FULL), $urandom_range(0, 1));
		send_pixel(SAMPLE_BITS'(-3), 1'b1);
		send_pixel(SAMPLE_BITS'(2), 1'b1);
		send_pixel(pick_temp(TEMP_FULL), $urandom_range(0, 1));
		send_pixel(pick_temp(TEMP_FULL), $urandom_range(0, 1));

		phase = 0;
		while (pixels_sent < ITEM_TARGET) begin
			phase++;
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				// Stall the output long enough for the summary queue to fill.
				tx_quiet = 1'b1;
				drain_results();
				apply_setting(2, 2, 0, 0, 1, 1);
				hold_requests++;
				send_frames(2, 2, 16, TEMP_FULL, 100);
			end else begin
				w = pick_size();
				h = pick_size();
				run_phase(w, h, pick_corner(frame_span(h)), pick_corner(frame_span(w)),
					pick_corner(frame_span(h)), pick_corner(frame_span(w)),
					$urandom_range(1, 3), temp_mode_t'($urandom_range(0, 3)),
					pick_valid_pct());
			end
		end

		drain_results();
		$display("Sent %0d pixels under %0d region settings, frames up to 12 x 12 pixels.",
			pixels_sent, settings_used);
		$display("Checked %0d frame results, %0d of them with region statistics.",
			frames_checked, frames_with_stats);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_results);
		$display("== FAIL ==");
		$finish;
	end

endmodule
